// ===== sv/dmx_pkg.sv =====
// Shared types and constants for the multichannel to stereo downmix block.
// Holds the channel count, gain format, register indexes and gain reset map.
// Depends on nothing; every other file of the block imports it.
package dmx_pkg;

   localparam int CHANNELS       = 6;
   localparam int GAIN_BITS      = 16;
   localparam int GAIN_FRAC_BITS = 15;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   typedef logic [GAIN_BITS-1:0]      gain_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [CSR_DATA_BITS-1:0]  csr_data_type;

   // Register indexes of the gain pairs, one per channel.
   localparam csr_index_type CSR_GAINS_CH0 = 3'd0;
   localparam csr_index_type CSR_GAINS_CH1 = 3'd1;
   localparam csr_index_type CSR_GAINS_CH2 = 3'd2;
   localparam csr_index_type CSR_GAINS_CH3 = 3'd3;
   localparam csr_index_type CSR_GAINS_CH4 = 3'd4;
   localparam csr_index_type CSR_GAINS_CH5 = 3'd5;

   // Default 5.1 map: unity, -3 dB (0x5A9E) and -6 dB (0x4027) in Q1.15.
   // Bits 15..0 are the left gain, bits 31..16 the right gain.
   localparam csr_data_type GAINS_RESET [CHANNELS] = '{
      32'h0000_8000, 32'h5A9E_5A9E, 32'h8000_0000,
      32'h0000_4027, 32'h4027_0000, 32'h4027_4027
   };

endpackage

// ===== sv/dmx_mix_lane.sv =====
// One output side of the downmix: multiply, two adder levels, scale and saturate.
// Four register stages with a valid bit per stage. Depends on dmx_pkg.
module dmx_mix_lane #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [SAMPLE_BITS-1:0] in_sample [dmx_pkg::CHANNELS],
   input  dmx_pkg::gain_type             in_gain   [dmx_pkg::CHANNELS],
   output logic                          out_valid,
   output logic signed [SAMPLE_BITS-1:0] out_mix,
   output logic                          out_clip
);
   import dmx_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + GAIN_BITS;
   localparam int SUM_W  = PROD_W + $clog2(CHANNELS);
   localparam int PAIRS  = (CHANNELS + 1) / 2;
   localparam int TOP_LO = GAIN_FRAC_BITS + SAMPLE_BITS - 1;

   localparam logic signed [SAMPLE_BITS-1:0] MIX_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] MIX_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic                     s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic signed [PROD_W-1:0] samp_ext [CHANNELS];
   logic signed [PROD_W-1:0] gain_ext [CHANNELS];
   logic signed [PROD_W-1:0] prod_in  [CHANNELS];
   logic signed [PROD_W-1:0] prod_ff  [CHANNELS];
   logic signed [SUM_W-1:0]  pair_in  [PAIRS];
   logic signed [SUM_W-1:0]  pair_ff  [PAIRS];
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:TOP_LO]    sum_top;
   logic                     ovf;
   logic signed [SAMPLE_BITS-1:0] mix_in;
   logic signed [SAMPLE_BITS-1:0] mix_ff;
   logic                     clip_ff;

   // Stage 1: one product per channel. Both operands are widened first so
   // the product keeps all of its bits.
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         samp_ext[c] = PROD_W'(in_sample[c]);
         gain_ext[c] = $signed(PROD_W'(in_gain[c]));
         prod_in[c]  = samp_ext[c] * gain_ext[c];
      end
   end

   // Stage 2: products added in pairs.
   for (genvar k = 0; k < PAIRS; k++) begin : g_pair
      if (2 * k + 1 < CHANNELS) begin : g_two
         assign pair_in[k] = SUM_W'(prod_ff[2*k]) + SUM_W'(prod_ff[2*k+1]);
      end else begin : g_one
         assign pair_in[k] = SUM_W'(prod_ff[2*k]);
      end
   end

   // Stage 3: the pair sums added into the exact total.
   always_comb begin
      sum_in = '0;
      for (int k = 0; k < PAIRS; k++) begin
         sum_in = sum_in + pair_ff[k];
      end
   end

   // Stage 4: dropping the fraction bits is a floor shift; the bits above the
   // result's sign must all match it, otherwise the mix saturates.
   assign sum_top = sum_ff[SUM_W-1:TOP_LO];
   assign ovf     = !((&sum_top) || !(|sum_top));
   assign mix_in  = ovf ? (sum_ff[SUM_W-1] ? MIX_MIN : MIX_MAX)
                        : sum_ff[TOP_LO:GAIN_FRAC_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         prod_ff <= prod_in;
      end
      if (s1_valid_ff) begin
         pair_ff <= pair_in;
      end
      if (s2_valid_ff) begin
         sum_ff <= sum_in;
      end
      if (s3_valid_ff) begin
         mix_ff  <= mix_in;
         clip_ff <= ovf;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_mix   = mix_ff;
   assign out_clip  = clip_ff;

endmodule

// ===== sv/multichannel_to_stereo_downmix_top.sv =====
// Top level of the 5.1 to stereo downmix: gain registers and two mix lanes.
// Depends on dmx_pkg and dmx_mix_lane.
//
// Usage:
// A frame of six signed samples (L C R Ls Rs LFE) is presented on the req_
// ports with start high. The frame is taken at any rising edge where start
// is high and busy is low. Busy never rises, so one frame can be taken on
// every clock cycle.
// Once a frame is taken and has passed the lane stages, rsp_strobe is high for one cycle.
// During that cycle, rsp_mix_left, rsp_mix_right and rsp_clipped carry the
// result for that frame. Results leave in the order their frames came in.
// The receiver cannot stall: a beat is consumed at the edge that ends its
// strobe cycle.
// Latency and throughput come from the lane pipeline: a multiplier stage, a
// pairwise adder stage, a final adder stage and a scale/saturate stage. One
// beat per cycle is sustained.
// Each channel's left and right gain is an unsigned Q1.15 value in one
// 32-bit register. The register is written through csr_we, csr_index and
// csr_wdata. Writes to an index beyond the last channel are dropped.
// Gains are read live by the multiplier stage, so the user must change them
// only while no frame is in flight; the block itself does not enforce it.
// A synchronous reset empties the pipeline, so no strobe follows it. Reset
// also reloads the default 5.1 gain map.
module multichannel_to_stereo_downmix_top #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_ch0,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_ch1,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_ch2,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_ch3,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_ch4,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_ch5,
   output logic                          rsp_strobe,
   output logic signed [SAMPLE_BITS-1:0] rsp_mix_left,
   output logic signed [SAMPLE_BITS-1:0] rsp_mix_right,
   output logic                          rsp_clipped,
   input  logic                          csr_we,
   input  dmx_pkg::csr_index_type        csr_index,
   input  dmx_pkg::csr_data_type         csr_wdata
);
   import dmx_pkg::*;

   csr_data_type gains_ff [CHANNELS];
   csr_data_type gains_in [CHANNELS];

   logic signed [SAMPLE_BITS-1:0] samples [CHANNELS];
   gain_type                      gain_l  [CHANNELS];
   gain_type                      gain_r  [CHANNELS];
   logic                          accept;
   logic                          valid_l, valid_r, clip_l, clip_r;

   // No frame is ever held off.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign samples[0] = req_sample_ch0;
   assign samples[1] = req_sample_ch1;
   assign samples[2] = req_sample_ch2;
   assign samples[3] = req_sample_ch3;
   assign samples[4] = req_sample_ch4;
   assign samples[5] = req_sample_ch5;

   // Gain register file. An index past the last channel takes the default arm and
   // leaves every register unchanged.
   always_comb begin
      gains_in = gains_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GAINS_CH0: gains_in[0] = csr_wdata;
            CSR_GAINS_CH1: gains_in[1] = csr_wdata;
            CSR_GAINS_CH2: gains_in[2] = csr_wdata;
            CSR_GAINS_CH3: gains_in[3] = csr_wdata;
            CSR_GAINS_CH4: gains_in[4] = csr_wdata;
            CSR_GAINS_CH5: gains_in[5] = csr_wdata;
            default:       gains_in = gains_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff <= GAINS_RESET;
      end else begin
         gains_ff <= gains_in;
      end
   end

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         gain_l[c] = gains_ff[c][GAIN_BITS-1:0];
         gain_r[c] = gains_ff[c][2*GAIN_BITS-1:GAIN_BITS];
      end
   end

   dmx_mix_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_left (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_sample (samples),
      .in_gain   (gain_l),
      .out_valid (valid_l),
      .out_mix   (rsp_mix_left),
      .out_clip  (clip_l)
   );

   dmx_mix_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_right (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_sample (samples),
      .in_gain   (gain_r),
      .out_valid (valid_r),
      .out_mix   (rsp_mix_right),
      .out_clip  (clip_r)
   );

   // Both lanes run in lockstep, so their valid bits always agree.
   assign rsp_strobe  = valid_l && valid_r;
   assign rsp_clipped = clip_l || clip_r;

endmodule

// ===== sv/dmx_checker.sv =====
// Port-level checks for the downmix top level, attached to it by a bind.
// Depends on dmx_pkg and on the port list of multichannel_to_stereo_downmix_top.
module dmx_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_strobe,
   input logic signed [SAMPLE_BITS-1:0] rsp_mix_left,
   input logic signed [SAMPLE_BITS-1:0] rsp_mix_right,
   input logic                          rsp_clipped
);
   import dmx_pkg::*;

   localparam logic signed [SAMPLE_BITS-1:0] MIX_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] MIX_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // Every taken frame yields a matching result beat.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_strobe)
      else $error("downmix: no result beat four cycles after a frame");

   // No beat appears without a matching taken frame.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##4 !rsp_strobe)
      else $error("downmix: result beat without a matching frame");

   // Reset empties the pipeline.
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("downmix: result beat right after reset");

   // A clipped beat carries a full-scale value on at least one side.
   a_clip_full_scale: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_clipped) |->
         (rsp_mix_left == MIX_MAX || rsp_mix_left == MIX_MIN ||
          rsp_mix_right == MIX_MAX || rsp_mix_right == MIX_MIN))
      else $error("downmix: clip flag without a saturated mix");

endmodule

bind multichannel_to_stereo_downmix_top dmx_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_dmx_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_mix_left  (rsp_mix_left),
   .rsp_mix_right (rsp_mix_right),
   .rsp_clipped   (rsp_clipped)
);
